// File: rtl/snn_config_packet_encoder_defines.svh
// Assertion macros for the configuration packet encoder.
`ifndef SNN_CONFIG_PACKET_ENCODER_DEFINES_SVH
`define SNN_CONFIG_PACKET_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cpe assertion failed");
`define CPE_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cpe assertion failed");
`else
`define CPE_ASSERT(lbl, clk, rstn, prop)
`define CPE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// File: rtl/snn_cpe_pkg.sv
package snn_cpe_pkg;

  typedef enum logic [2:0] {
    KIND_GLOBAL  = 3'd0,
    KIND_NEURON  = 3'd1,
    KIND_SYNAPSE = 3'd2,
    KIND_SIGN    = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  localparam logic [3:0] ADDR_TOP_NEURON  = 4'b0101;
  localparam logic [3:0] ADDR_TOP_SYNAPSE = 4'b0110;
  localparam logic [4:0] SIGN_REG_BASE    = 5'd2;
  localparam logic [7:0] SYN_MASK_ODD     = 8'h0F;
  localparam logic [7:0] SYN_MASK_EVEN    = 8'hF0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  target;
    logic [7:0]  post_id;
    logic [2:0]  weight;
    logic        flag_bit;
    logic [19:0] value;
    logic [39:0] lif;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [39:0] packet;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic       clr;
    logic       wr;
    logic [3:0] word;
    logic [3:0] bit_sel;
    logic       set;
  } cache_req_t;

  function automatic logic [39:0] lif_word(
    input logic [7:0]  thr,
    input logic [6:0]  leak_str,
    input logic        leak_en,
    input logic        ca_en,
    input logic [7:0]  thetamem,
    input logic [13:0] ca_params
  );
    return {ca_params[13:9], ca_params[8:0], thetamem, ca_en, thr, leak_en, leak_str, 1'b1};
  endfunction

endpackage

// File: rtl/snn_config_packet_encoder.sv
// Configuration packet encoder for a 256-neuron spiking chip.
// Slave side: one command per beat. s_axis_tuser carries the command kind,
// s_axis_tdata the operand fields. Master side: one 40-bit packet per beat
// (address in bits 39:20, data in bits 19:0), m_axis_tlast marks the final
// packet of a command.
// Global write, synapse and sign update commands give one packet, a neuron
// LIF command gives sixteen, a cache clear, a sign update past the last
// neuron or an unknown kind gives none.
// Packets leave one per cycle while the receiver does not stall, from a
// byte shifter under a beat counter; s_axis_tready is low while a command
// is being emitted. The command is registered in the sequencer before its
// first packet enters the output register. No new command is taken until
// its last packet is registered; clear and ignored commands leave it idle.
// The master side has an output register; when the receiver stalls, the
// sequencer holds its counter and the packet stays on m_axis_tdata.
// Reset clears the sign cache, the sequencer state and beat counter and
// the output valid; the block is ready for a command once reset is released.
`include "snn_config_packet_encoder_defines.svh"

module snn_config_packet_encoder #(
  parameter int unsigned NEURON_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target[7:0], post_id[15:8], weight[18:16], flag_bit[19], value[39:20],
  // thr[47:40], leak_str[54:48], leak_en[55], ca_en[56], thetamem[64:57],
  // ca_params[78:65], zero pad[79]
  input  logic [79:0] s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // packet[39:0]
  output logic [39:0] m_axis_tdata,
  // last
  output logic        m_axis_tlast
);
  import snn_cpe_pkg::*;

  cmd_t        cmd;
  beat_t       beat;
  cache_req_t  cache_req;
  logic [15:0] cache_word;
  logic        busy;
  logic        accept;
  logic        out_free;
  logic        out_hold;
  logic        m_valid_q;
  logic [39:0] m_data_q;
  logic        m_last_q;

  assign cmd.kind     = s_axis_tuser;
  assign cmd.target   = s_axis_tdata[7:0];
  assign cmd.post_id  = s_axis_tdata[15:8];
  assign cmd.weight   = s_axis_tdata[18:16];
  assign cmd.flag_bit = s_axis_tdata[19];
  assign cmd.value    = s_axis_tdata[39:20];
  assign cmd.lif      = lif_word(s_axis_tdata[47:40], s_axis_tdata[54:48],
                                 s_axis_tdata[55], s_axis_tdata[56],
                                 s_axis_tdata[64:57], s_axis_tdata[78:65]);

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_hold      = m_valid_q && !m_axis_tready;

  snn_cpe_seq #(
    .NEURON_COUNT(NEURON_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd),
    .out_free_i  (out_free),
    .cache_word_i(cache_word),
    .busy_o      (busy),
    .beat_o      (beat),
    .cache_req_o (cache_req)
  );

  snn_cpe_cache #(
    .NEURON_COUNT(NEURON_COUNT)
  ) u_cache (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (cache_req),
    .word_o(cache_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (beat.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat.valid) begin
      m_data_q <= beat.packet;
      m_last_q <= beat.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // a held beat seen while idle must be the end of its command
  `CPE_ASSERT(a_idle_holds_last, clk_i, rst_ni, (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
  `CPE_ASSERT(a_neuron_busy, clk_i, rst_ni, (accept && (s_axis_tuser == KIND_NEURON)) |=> !s_axis_tready)
  `CPE_ASSERT(a_stall_hold, clk_i, rst_ni, out_hold |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

// File: rtl/snn_cpe_cache.sv
module snn_cpe_cache #(
  parameter int unsigned NEURON_COUNT = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  snn_cpe_pkg::cache_req_t req_i,
  output logic [15:0]             word_o
);
  import snn_cpe_pkg::*;

  localparam int unsigned SIGN_WORDS = (NEURON_COUNT + 15) / 16;
  localparam int unsigned WORD_W     = (SIGN_WORDS > 1) ? $clog2(SIGN_WORDS) : 1;

  logic [15:0]       cache_q [SIGN_WORDS];
  logic [WORD_W-1:0] idx;
  logic [15:0]       old_word;
  logic [15:0]       mask;

  assign idx      = req_i.word[WORD_W-1:0];
  assign mask     = 16'b1 << req_i.bit_sel;
  assign old_word = cache_q[idx];
  // updated word, written back on wr
  assign word_o   = req_i.set ? (old_word | mask) : (old_word & ~mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_q <= '{default: '0};
    end else if (req_i.clr) begin
      cache_q <= '{default: '0};
    end else if (req_i.wr) begin
      cache_q[idx] <= word_o;
    end
  end

endmodule

// File: rtl/snn_cpe_seq.sv
module snn_cpe_seq #(
  parameter int unsigned NEURON_COUNT = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  snn_cpe_pkg::cmd_t       cmd_i,
  input  logic                    out_free_i,
  input  logic [15:0]             cache_word_i,
  output logic                    busy_o,
  output snn_cpe_pkg::beat_t      beat_o,
  output snn_cpe_pkg::cache_req_t cache_req_o
);
  import snn_cpe_pkg::*;

  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [39:0] sh_q, sh_d;
  cmd_t        cmd_q, cmd_d;
  logic [19:0] addr;
  logic [19:0] data;
  logic        last;
  logic [3:0]  nib;
  logic        in_range;

  assign nib      = {cmd_q.flag_bit, cmd_q.weight};
  assign in_range = {1'b0, cmd_i.target} < 9'(NEURON_COUNT);
  assign busy_o   = (state_q != ST_IDLE);

  always_comb begin
    addr = '0;
    data = '0;
    last = 1'b1;
    case (cmd_q.kind)
      KIND_GLOBAL: begin
        addr = {15'b0, cmd_q.target[4:0]};
        data = cmd_q.value;
      end
      KIND_NEURON: begin
        addr = {ADDR_TOP_NEURON, 4'b0, cnt_q, cmd_q.target};
        data = {12'b0, sh_q[7:0]};
        last = (cnt_q == 4'hF);
      end
      KIND_SYNAPSE: begin
        addr = {ADDR_TOP_SYNAPSE, 1'b0, cmd_q.post_id[2:1], cmd_q.target, cmd_q.post_id[7:3]};
        if (cmd_q.post_id[0]) begin
          data = {4'b0, SYN_MASK_ODD, nib, 4'b0};
        end else begin
          data = {4'b0, SYN_MASK_EVEN, 4'b0, nib};
        end
      end
      KIND_SIGN: begin
        addr = {15'b0, SIGN_REG_BASE + {1'b0, cmd_q.target[7:4]}};
        data = {4'b0, cache_word_i};
      end
      default: begin
        addr = '0;
      end
    endcase
  end

  always_comb begin
    state_d             = state_q;
    cnt_d               = cnt_q;
    sh_d                = sh_q;
    cmd_d               = cmd_q;
    beat_o              = '0;
    cache_req_o         = '0;
    cache_req_o.word    = cmd_q.target[7:4];
    cache_req_o.bit_sel = cmd_q.target[3:0];
    cache_req_o.set     = cmd_q.flag_bit;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          cmd_d = cmd_i;
          sh_d  = cmd_i.lif;
          cnt_d = '0;
          case (cmd_i.kind)
            KIND_GLOBAL, KIND_NEURON, KIND_SYNAPSE: begin
              state_d = ST_EMIT;
            end
            KIND_SIGN: begin
              if (in_range) begin
                state_d = ST_EMIT;
              end
            end
            KIND_CLEAR: begin
              cache_req_o.clr = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          beat_o.valid  = 1'b1;
          beat_o.packet = {addr, data};
          beat_o.last   = last;
          sh_d          = sh_q >> 8;
          cnt_d         = cnt_q + 4'd1;
          if (cmd_q.kind == KIND_SIGN) begin
            cache_req_o.wr = 1'b1;
          end
          if (last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    cmd_q <= cmd_d;
  end

endmodule

// File: bench/snn_cpe_bench_pkg.sv
package snn_cpe_bench_pkg;

  // s_axis_tdata layout, lowest field last
  typedef struct packed {
    logic        pad;
    logic [13:0] ca_params;
    logic [7:0]  thetamem;
    logic        ca_en;
    logic        leak_en;
    logic [6:0]  leak_str;
    logic [7:0]  thr;
    logic [19:0] value;
    logic        flag_bit;
    logic [2:0]  weight;
    logic [7:0]  post_id;
    logic [7:0]  target;
  } cmd_fields_t;

  typedef struct packed {
    logic [39:0] packet;
    logic        last;
  } packet_beat_t;

  // kinds the block ignores
  localparam logic [2:0] KIND_RSVD_LO  = 3'd5;
  localparam logic [2:0] KIND_RSVD_MID = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI  = 3'd7;

endpackage

// File: bench/snn_config_packet_encoder_checker.sv
module snn_config_packet_encoder_checker #(
  parameter int unsigned NEURON_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          pending_o,
  output int          fail_count_o,
  output int          packets_checked_o
);
  import snn_cpe_pkg::*;
  import snn_cpe_bench_pkg::*;

  logic [15:0]  sign_bits [16];
  packet_beat_t packets_due [$];
  int           failures = 0;
  int           checked  = 0;

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic queue_packet(input logic [19:0] addr, input logic [19:0] data,
                              input logic last);
    packet_beat_t p;
    p.packet = {addr, data};
    p.last   = last;
    packets_due.insert(packets_due.size(), p);
  endtask

  task automatic encode_command(input logic [2:0] kind, input cmd_fields_t f);
    logic [39:0] lif;
    logic [3:0]  nib;
    logic [3:0]  word;
    logic [19:0] data;
    case (kind)
      KIND_GLOBAL: begin
        queue_packet({15'd0, f.target[4:0]}, f.value, 1'b1);
      end
      KIND_NEURON: begin
        lif = {f.ca_params, f.thetamem, f.ca_en, f.thr, f.leak_en, f.leak_str, 1'b1};
        for (int b = 0; b < 16; b++) begin
          data = (b < 5) ? {12'd0, lif[8*b +: 8]} : 20'd0;
          queue_packet({ADDR_TOP_NEURON, 4'd0, 4'(b), f.target}, data, b == 15);
        end
      end
      KIND_SYNAPSE: begin
        nib = {f.flag_bit, f.weight};
        if (f.post_id[0]) begin
          data = (20'(SYN_MASK_ODD) << 8) | (20'(nib) << 4);
        end else begin
          data = (20'(SYN_MASK_EVEN) << 8) | 20'(nib);
        end
        queue_packet({ADDR_TOP_SYNAPSE, 1'b0, f.post_id[2:1], f.target, f.post_id[7:3]},
                     data, 1'b1);
      end
      KIND_SIGN: begin
        if (32'(f.target) < NEURON_COUNT) begin
          word = f.target[7:4];
          sign_bits[word][f.target[3:0]] = f.flag_bit;
          queue_packet({15'd0, SIGN_REG_BASE + {1'b0, word}}, {4'd0, sign_bits[word]}, 1'b1);
        end
      end
      KIND_CLEAR: begin
        foreach (sign_bits[i]) sign_bits[i] = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    packet_beat_t want;
    if (!rst_ni) begin
      foreach (sign_bits[i]) sign_bits[i] = '0;
      packets_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_command(s_axis_tuser, cmd_fields_t'(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (packets_due.size() == 0) begin
          note_failure($sformatf("packet %h last %b with nothing expected",
                                 m_axis_tdata, m_axis_tlast));
        end else begin
          want = packets_due.pop_front();
          checked++;
          if (m_axis_tdata !== want.packet) begin
            note_failure($sformatf("packet: expected %h, got %h", want.packet, m_axis_tdata));
          end
          if (m_axis_tlast !== want.last) begin
            note_failure($sformatf("last: expected %b, got %b (packet %h)",
                                   want.last, m_axis_tlast, want.packet));
          end
        end
      end
    end
    pending_o         <= packets_due.size();
    fail_count_o      <= failures;
    packets_checked_o <= checked;
  end

endmodule

// File: bench/snn_config_packet_encoder_tb.sv
module snn_config_packet_encoder_tb;
  import snn_cpe_pkg::*;
  import snn_cpe_bench_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 120;
  localparam int ITEMS_PER_PHASE = 68;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  int pending;
  int fail_count;
  int packets_checked;
  int kind_count [8] = '{default: 0};

  snn_config_packet_encoder #(
    .NEURON_COUNT(256)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  snn_config_packet_encoder_checker #(
    .NEURON_COUNT(256)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .pending_o        (pending),
    .fail_count_o     (fail_count),
    .packets_checked_o(packets_checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off per request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_req) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_served   <= hold_req;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // only expected packets count as progress on the master side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready && pending != 0)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d packets outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic cmd_fields_t random_fields();
    cmd_fields_t f;
    f     = cmd_fields_t'(80'({$urandom, $urandom, $urandom}));
    f.pad = 1'b0;
    return f;
  endfunction

  task automatic send_cmd(input logic [2:0] kind, input cmd_fields_t f);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= f;
    kind_count[kind]++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_sign(input logic [7:0] target, input logic flag_bit);
    cmd_fields_t f;
    f          = random_fields();
    f.target   = target;
    f.flag_bit = flag_bit;
    send_cmd(KIND_SIGN, f);
  endtask

  task automatic send_synapse(input logic [7:0] target, input logic [7:0] post_id,
                              input logic [2:0] weight, input logic flag_bit);
    cmd_fields_t f;
    f          = random_fields();
    f.target   = target;
    f.post_id  = post_id;
    f.weight   = weight;
    f.flag_bit = flag_bit;
    send_cmd(KIND_SYNAPSE, f);
  endtask

  task automatic send_random_cmd();
    cmd_fields_t f;
    logic [2:0]  kind;
    int          pick;
    f    = random_fields();
    pick = $urandom_range(99);
    if (pick < 18) kind = KIND_GLOBAL;
    else if (pick < 33) kind = KIND_NEURON;
    else if (pick < 58) kind = KIND_SYNAPSE;
    else if (pick < 88) kind = KIND_SIGN;
    else if (pick < 93) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
    // keep half of the sign updates on words 0 to 2 so bits pile up
    if (kind == KIND_SIGN && $urandom_range(1) == 1) begin
      f.target[7:4] = 4'($urandom_range(2));
    end
    send_cmd(kind, f);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_phase(input int sender_idle, input int recv_stall);
    idle_pct  = sender_idle;
    stall_pct <= recv_stall;
    repeat (ITEMS_PER_PHASE) send_random_cmd();
    wait_drained();
  endtask

  initial begin
    cmd_fields_t f;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    f = random_fields(); f.target = 8'h00; f.value = 20'h00000;
    send_cmd(KIND_GLOBAL, f);
    f = random_fields(); f.target = 8'hFF; f.value = 20'hFFFFF;
    send_cmd(KIND_GLOBAL, f);
    f = random_fields(); f.target = 8'h22;
    send_cmd(KIND_GLOBAL, f);
    f = random_fields();
    f.target = 8'h00; f.thr = '0; f.leak_str = '0; f.leak_en = 1'b0;
    f.ca_en = 1'b0; f.thetamem = '0; f.ca_params = '0;
    send_cmd(KIND_NEURON, f);
    f = random_fields();
    f.target = 8'hFF; f.thr = '1; f.leak_str = '1; f.leak_en = 1'b1;
    f.ca_en = 1'b1; f.thetamem = '1; f.ca_params = '1;
    send_cmd(KIND_NEURON, f);
    send_cmd(KIND_NEURON, random_fields());
    send_synapse(8'h00, 8'h00, 3'd0, 1'b0);
    send_synapse(8'hFF, 8'hFF, 3'd7, 1'b1);
    send_synapse(8'h81, 8'h0A, 3'd5, 1'b0);
    send_synapse(8'h3C, 8'hF5, 3'd2, 1'b1);
    send_sign(8'h00, 1'b1);
    send_sign(8'h0F, 1'b1);
    send_sign(8'h00, 1'b0);
    send_sign(8'hFF, 1'b1);
    send_sign(8'h80, 1'b1);
    send_sign(8'h80, 1'b1);
    send_cmd(KIND_CLEAR, random_fields());
    send_sign(8'h0F, 1'b0);
    send_sign(8'hFF, 1'b0);
    send_cmd(KIND_RSVD_LO, random_fields());
    send_cmd(KIND_RSVD_MID, random_fields());
    send_cmd(KIND_RSVD_HI, random_fields());
    f = random_fields(); f.target = 8'h1F;
    send_cmd(KIND_GLOBAL, f);
    wait_drained();

    // long output hold while commands keep coming in
    hold_req <= hold_req + 1;
    repeat (6) begin
      send_cmd(KIND_NEURON, random_fields());
      send_synapse(8'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
    end
    wait_drained();

    run_phase(0, 0);
    run_phase(56, 0);
    run_phase(0, 56);
    run_phase(30, 30);

    repeat (20) @(posedge clk_i);
    $display("commands: %0d global, %0d neuron, %0d synapse, %0d sign, %0d clear, %0d ignored",
             kind_count[KIND_GLOBAL], kind_count[KIND_NEURON], kind_count[KIND_SYNAPSE],
             kind_count[KIND_SIGN], kind_count[KIND_CLEAR],
             kind_count[KIND_RSVD_LO] + kind_count[KIND_RSVD_MID] + kind_count[KIND_RSVD_HI]);
    $display("%0d packets compared over four idle/stall mixes and one long output hold",
             packets_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d packets never arrived", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
